### rtl/srfcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfcm_pkg
// Shared types and constants for the serial ring buffer pair with
// character match.
// ----------------------------------------------------------------------------
package srfcm_pkg;

    typedef enum logic [2:0] {
        FUNC_PUT_TX   = 3'd0,
        FUNC_TX_DONE  = 3'd1,
        FUNC_RX_BYTE  = 3'd2,
        FUNC_READ_RX  = 3'd3,
        FUNC_FLUSH_TX = 3'd4,
        FUNC_FLUSH_RX = 3'd5
    } func_t;

    // per-cycle control for one ring
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } ring_ctrl_t;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_T  = 8'h74;
    localparam logic [7:0] CHAR_E  = 8'h65;
    localparam logic [7:0] CHAR_F  = 8'h66;
    localparam logic [7:0] CHAR_L  = 8'h4C;

    localparam int LEVEL_W = 7;

endpackage

### rtl/srfcm_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfcm_ring
// Byte ring buffer: storage array, read and write pointers, fill count and
// registered read data.
// ----------------------------------------------------------------------------
module srfcm_ring #(
    parameter int DEPTH  = 64,
    parameter int PTR_W  = $clog2(DEPTH),
    parameter int FILL_W = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  srfcm_pkg::ring_ctrl_t  ctrl,
    input  logic [7:0]             wdata,
    output logic [7:0]             rdata,
    output logic [FILL_W-1:0]      fill,
    output logic                   empty,
    output logic                   full
);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rdata_reg;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == FILL_W'(DEPTH));
    assign fill  = fill_reg;
    assign rdata = rdata_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (ctrl.flush)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
        end
        else if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage and registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.flush)
            mem[wr_ptr_reg] <= wdata;
        if (ctrl.pop && !ctrl.flush)
            rdata_reg <= mem[rd_ptr_reg];
    end

endmodule

### rtl/srfcm_char_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfcm_char_match
// Mode-dependent matcher for received bytes: carriage return in command
// mode, t, e, f or L in data mode.
// ----------------------------------------------------------------------------
module srfcm_char_match (
    input  logic       command_mode,
    input  logic [7:0] data_byte,
    output logic       line_end,
    output logic       command_char
);

    logic is_cmd_char;

    assign is_cmd_char = (data_byte == srfcm_pkg::CHAR_T) ||
                         (data_byte == srfcm_pkg::CHAR_E) ||
                         (data_byte == srfcm_pkg::CHAR_F) ||
                         (data_byte == srfcm_pkg::CHAR_L);

    assign line_end     = command_mode && (data_byte == srfcm_pkg::CHAR_CR);
    assign command_char = !command_mode && is_cmd_char;

endmodule

### rtl/serial_ring_fifo_with_char_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_ring_fifo_with_char_match_unit
// Transmit and receive byte rings for a serial port, with direct send,
// drop flags and received-character matching.
// ----------------------------------------------------------------------------
// One operation is taken on every clock cycle: busy is always low and start
// may stay high. Each transfer is registered in the input register,
// processed against the ring pointers and fill counts in the following cycle,
// and its result is registered in the result register and shown with done,
// one result per operation.
// The rate is set by the pointer and count update of each ring and its storage
// array with registered read data. The receiver cannot stall, so every result
// must be taken in the cycle it is shown.
// command_mode is written through cfg_we and cfg_data; the user must write it
// only while no operation is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
module serial_ring_fifo_with_char_match_unit #(
    parameter int RING_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] func,
    input  logic [7:0] data_byte,
    input  logic       tx_ready,
    input  logic       cfg_we,
    input  logic       cfg_data,
    output logic       done,
    output logic       send_valid,
    output logic [7:0] send_byte,
    output logic [7:0] read_byte,
    output logic       read_empty,
    output logic [6:0] tx_level,
    output logic [6:0] rx_level,
    output logic       line_end_seen,
    output logic       command_char_seen,
    output logic       rx_dropped,
    output logic       tx_dropped
);

    localparam int FILL_W = $clog2(RING_DEPTH + 1);

    logic       command_mode_reg;
    logic       item_valid_reg;
    logic [2:0] func_reg;
    logic [7:0] data_reg;
    logic       ready_reg;

    srfcm_pkg::ring_ctrl_t tx_ctrl, rx_ctrl;
    logic [7:0]        tx_rdata, rx_rdata;
    logic [FILL_W-1:0] tx_fill, rx_fill;
    logic              tx_empty, tx_full, rx_empty, rx_full;
    logic              match_line_end, match_cmd_char;

    logic send_valid_next, from_ring_next, read_pop_next, read_empty_next;
    logic line_end_next, cmd_char_next, rx_drop_next, tx_drop_next;
    logic [7:0] direct_byte_next;

    logic done_reg, send_valid_reg, from_ring_reg, read_pop_reg, read_empty_reg;
    logic line_end_reg, cmd_char_reg, rx_drop_reg, tx_drop_reg;
    logic [7:0] direct_byte_reg;

    logic [FILL_W+srfcm_pkg::LEVEL_W-1:0] tx_fill_ext, rx_fill_ext;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            command_mode_reg <= 1'b0;
        else if (cfg_we)
            command_mode_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg  <= func;
            data_reg  <= data_byte;
            ready_reg <= tx_ready;
        end
    end

    srfcm_ring #(
        .DEPTH (RING_DEPTH)
    ) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tx_ctrl),
        .wdata (data_reg),
        .rdata (tx_rdata),
        .fill  (tx_fill),
        .empty (tx_empty),
        .full  (tx_full)
    );

    srfcm_ring #(
        .DEPTH (RING_DEPTH)
    ) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rx_ctrl),
        .wdata (data_reg),
        .rdata (rx_rdata),
        .fill  (rx_fill),
        .empty (rx_empty),
        .full  (rx_full)
    );

    srfcm_char_match u_char_match (
        .command_mode (command_mode_reg),
        .data_byte    (data_reg),
        .line_end     (match_line_end),
        .command_char (match_cmd_char)
    );

    always_comb
    begin
        tx_ctrl          = '0;
        rx_ctrl          = '0;
        send_valid_next  = 1'b0;
        from_ring_next   = 1'b0;
        direct_byte_next = '0;
        read_pop_next    = 1'b0;
        read_empty_next  = 1'b0;
        line_end_next    = 1'b0;
        cmd_char_next    = 1'b0;
        rx_drop_next     = 1'b0;
        tx_drop_next     = 1'b0;
        if (item_valid_reg)
        begin
            unique case (func_reg)
                srfcm_pkg::FUNC_PUT_TX:
                begin
                    if (ready_reg && tx_empty)
                    begin
                        send_valid_next  = 1'b1;
                        direct_byte_next = data_reg;
                    end
                    else if (tx_full)
                        tx_drop_next = 1'b1;
                    else
                        tx_ctrl.push = 1'b1;
                end
                srfcm_pkg::FUNC_TX_DONE:
                begin
                    if (!tx_empty)
                    begin
                        tx_ctrl.pop     = 1'b1;
                        send_valid_next = 1'b1;
                        from_ring_next  = 1'b1;
                    end
                end
                srfcm_pkg::FUNC_RX_BYTE:
                begin
                    if (rx_full)
                        rx_drop_next = 1'b1;
                    else
                    begin
                        rx_ctrl.push  = 1'b1;
                        line_end_next = match_line_end;
                        cmd_char_next = match_cmd_char;
                    end
                end
                srfcm_pkg::FUNC_READ_RX:
                begin
                    if (rx_empty)
                        read_empty_next = 1'b1;
                    else
                    begin
                        rx_ctrl.pop   = 1'b1;
                        read_pop_next = 1'b1;
                    end
                end
                srfcm_pkg::FUNC_FLUSH_TX: tx_ctrl.flush = 1'b1;
                srfcm_pkg::FUNC_FLUSH_RX: rx_ctrl.flush = 1'b1;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            send_valid_reg <= 1'b0;
            from_ring_reg  <= 1'b0;
            read_pop_reg   <= 1'b0;
            read_empty_reg <= 1'b0;
            line_end_reg   <= 1'b0;
            cmd_char_reg   <= 1'b0;
            rx_drop_reg    <= 1'b0;
            tx_drop_reg    <= 1'b0;
        end
        else
        begin
            done_reg       <= item_valid_reg;
            send_valid_reg <= send_valid_next;
            from_ring_reg  <= from_ring_next;
            read_pop_reg   <= read_pop_next;
            read_empty_reg <= read_empty_next;
            line_end_reg   <= line_end_next;
            cmd_char_reg   <= cmd_char_next;
            rx_drop_reg    <= rx_drop_next;
            tx_drop_reg    <= tx_drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        direct_byte_reg <= direct_byte_next;
    end

    // ring read data is already registered, so only a select remains here
    assign done              = done_reg;
    assign send_valid        = send_valid_reg;
    assign send_byte         = !send_valid_reg ? 8'h00 :
                               (from_ring_reg ? tx_rdata : direct_byte_reg);
    assign read_byte         = read_pop_reg ? rx_rdata : 8'h00;
    assign read_empty        = read_empty_reg;
    assign line_end_seen     = line_end_reg;
    assign command_char_seen = cmd_char_reg;
    assign rx_dropped        = rx_drop_reg;
    assign tx_dropped        = tx_drop_reg;

    // fill counts hold the state after the item being shown
    assign tx_fill_ext = {{srfcm_pkg::LEVEL_W{1'b0}}, tx_fill};
    assign rx_fill_ext = {{srfcm_pkg::LEVEL_W{1'b0}}, rx_fill};
    assign tx_level    = tx_fill_ext[srfcm_pkg::LEVEL_W-1:0];
    assign rx_level    = rx_fill_ext[srfcm_pkg::LEVEL_W-1:0];

    a_tx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_fill <= FILL_W'(RING_DEPTH))
        else $error("transmit fill count beyond ring depth");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted transfer produced no result");

    a_rx_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rx_dropped |-> (rx_fill == FILL_W'(RING_DEPTH)))
        else $error("receive byte dropped while ring not full");

    a_tx_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && func_reg == srfcm_pkg::FUNC_FLUSH_TX) |=> (tx_fill == '0))
        else $error("transmit ring not empty after flush");

    a_no_send_and_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(send_valid && (read_empty || rx_dropped)))
        else $error("transmit and receive results in one operation");

endmodule
